// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPCODE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNMASKED = 2'd3;

    localparam logic [3:0] OPCODE_TEXT = 4'h1;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [2:0] EXT_LEFT_16 = 3'd1;
    localparam logic [2:0] EXT_LEFT_64 = 3'd7;

    typedef struct packed {
        logic                has_result;
        logic [BYTE_W-1:0]   payload_byte;
        logic                byte_valid;
        logic                frame_done;
        logic [STATUS_W-1:0] frame_status;
    } wsd_result_t;

endpackage

// ===== rtl/wsd_if.sv =====
interface wsd_in_if;
    logic                         valid;
    logic                         ready;
    logic [wsd_pkg::BYTE_W-1:0]   data_byte;
    logic                         end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [wsd_pkg::BYTE_W-1:0]   payload_byte;
    logic                         byte_valid;
    logic                         frame_done;
    logic [wsd_pkg::STATUS_W-1:0] frame_status;

    modport source (output valid, output payload_byte, output byte_valid,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input byte_valid,
                    input frame_done, input frame_status, output ready);
endinterface

// ===== rtl/websocket_text_frame_deframer.sv =====
// Channel   Role   Beat payload
// in_ch     sink   data_byte, end_of_buffer
// out_ch    source payload_byte, byte_valid, frame_done, frame_status
//
// One byte per cycle sustained while results are taken; a result is offered once
// its byte has passed the input register, then parse logic into the output register.
// Reset (rst_n, async, active low) returns the parser to the first header byte.
// A stalled output holds its beat; the input register keeps taking bytes
// that give no result, and stops only when a result has nowhere to go.
module websocket_text_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    wsd_in_if.sink    in_ch,
    wsd_out_if.source out_ch
);

    logic                          in_valid_reg;
    logic [wsd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_last_reg;

    logic                          out_valid_reg;
    logic [wsd_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_bv_reg;
    logic                          out_done_reg;
    logic [wsd_pkg::STATUS_W-1:0]  out_status_reg;

    wsd_pkg::wsd_result_t          res;
    logic                          out_free;
    logic                          advance;
    logic                          load_out;

    wsd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_last_reg),
        .result        (res)
    );

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && (!res.has_result || out_free);
    assign load_out    = advance && res.has_result;
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_last_reg <= in_ch.end_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg   <= res.payload_byte;
            out_bv_reg     <= res.byte_valid;
            out_done_reg   <= res.frame_done;
            out_status_reg <= res.frame_status;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = out_byte_reg;
    assign out_ch.byte_valid   = out_bv_reg;
    assign out_ch.frame_done   = out_done_reg;
    assign out_ch.frame_status = out_status_reg;

    // every result carries a byte or closes a buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_bv_reg || out_done_reg))
        else $error("empty result beat");

    // status is only reported on the closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> (out_status_reg == wsd_pkg::ST_OK))
        else $error("status outside closing beat");

    // a byte held in the input register is not lost while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_last_reg)))
        else $error("input register changed while stalled");

    // a parsed result never overwrites a beat that was not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ch.ready))
        else $error("output overwritten");

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [wsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         end_of_buffer,
    output wsd_pkg::wsd_result_t         result
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4,
        PH_SKIP = 3'd5
    } phase_t;

    phase_t                        phase_reg,   phase_next;
    logic [wsd_pkg::LEN_W-1:0]     length_reg,  length_next;
    logic [2:0]                    ext_reg,     ext_next;
    logic [wsd_pkg::KEY_W-1:0]     key_reg,     key_next;
    logic [1:0]                    pos_reg,     pos_next;
    logic [wsd_pkg::STATUS_W-1:0]  pending_reg, pending_next;
    logic                          masked_reg,  masked_next;

    logic [wsd_pkg::STATUS_W-1:0]  status;
    logic [wsd_pkg::BYTE_W-1:0]    out_byte;
    logic                          out_valid;
    logic [wsd_pkg::BYTE_W-1:0]    key_byte;
    logic                          len_zero;
    logic                          len_one;

    assign len_zero = (length_reg == '0);
    assign len_one  = (length_reg == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1});

    always_comb
    begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        ext_next     = ext_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        masked_next  = masked_reg;
        status       = wsd_pkg::ST_TRUNC;
        out_byte     = '0;
        out_valid    = 1'b0;

        case (phase_reg)
            PH_HDR0:
            begin
                if (data_byte[3:0] != wsd_pkg::OPCODE_TEXT)
                begin
                    pending_next = wsd_pkg::ST_OPCODE;
                    phase_next   = PH_SKIP;
                end
                else
                begin
                    pending_next = wsd_pkg::ST_OK;
                    phase_next   = PH_HDR1;
                end
            end
            PH_HDR1:
            begin
                masked_next = data_byte[7];
                length_next = '0;
                if (data_byte[6:0] == wsd_pkg::LEN_CODE_16)
                begin
                    ext_next   = wsd_pkg::EXT_LEFT_16;
                    phase_next = PH_EXT;
                end
                else if (data_byte[6:0] == wsd_pkg::LEN_CODE_64)
                begin
                    ext_next   = wsd_pkg::EXT_LEFT_64;
                    phase_next = PH_EXT;
                end
                else
                begin
                    length_next = {{(wsd_pkg::LEN_W-7){1'b0}}, data_byte[6:0]};
                    if (!data_byte[7])
                    begin
                        pending_next = wsd_pkg::ST_UNMASKED;
                        phase_next   = PH_SKIP;
                        status       = wsd_pkg::ST_UNMASKED;
                    end
                    else
                    begin
                        pos_next   = 2'd0;
                        phase_next = PH_MASK;
                    end
                end
            end
            PH_EXT:
            begin
                length_next = {length_reg[wsd_pkg::LEN_W-9:0], data_byte};
                if (ext_reg == 3'd0)
                begin
                    if (!masked_reg)
                    begin
                        pending_next = wsd_pkg::ST_UNMASKED;
                        phase_next   = PH_SKIP;
                        status       = wsd_pkg::ST_UNMASKED;
                    end
                    else
                    begin
                        pos_next   = 2'd0;
                        phase_next = PH_MASK;
                    end
                end
                else
                begin
                    ext_next = ext_reg - 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[wsd_pkg::KEY_W-9:0], data_byte};
                if (pos_reg == 2'd3)
                begin
                    pos_next = 2'd0;
                    if (len_zero)
                    begin
                        phase_next = PH_SKIP;
                        status     = wsd_pkg::ST_OK;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 2'd1;
                end
            end
            PH_PAY:
            begin
                out_byte    = data_byte ^ key_byte;
                out_valid   = 1'b1;
                pos_next    = pos_reg + 2'd1;
                length_next = length_reg - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
                if (len_one)
                begin
                    phase_next = PH_SKIP;
                    status     = wsd_pkg::ST_OK;
                end
            end
            default:
            begin
                // skip to the end of the buffer, unused codes included
                status = pending_reg;
            end
        endcase
    end

    always_comb
    begin
        result.has_result   = out_valid | end_of_buffer;
        result.payload_byte = out_byte;
        result.byte_valid   = out_valid;
        result.frame_done   = end_of_buffer;
        result.frame_status = end_of_buffer ? status : wsd_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            length_reg  <= '0;
            ext_reg     <= '0;
            key_reg     <= '0;
            pos_reg     <= '0;
            pending_reg <= wsd_pkg::ST_OK;
            masked_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_buffer)
            begin
                // buffer closed: start over on the next header byte
                phase_reg   <= PH_HDR0;
                length_reg  <= '0;
                ext_reg     <= '0;
                key_reg     <= '0;
                pos_reg     <= '0;
                pending_reg <= wsd_pkg::ST_OK;
                masked_reg  <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                length_reg  <= length_next;
                ext_reg     <= ext_next;
                key_reg     <= key_next;
                pos_reg     <= pos_next;
                pending_reg <= pending_next;
                masked_reg  <= masked_next;
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [2:0] {
        HDR_FIRST,
        HDR_SECOND,
        EXT_LENGTH,
        KEY_BYTES,
        PAYLOAD_BYTES,
        SKIP_TAIL
    } parse_phase_t;

    typedef enum int {LEN7, LEN16, LEN64} len_form_t;

    logic clk;
    logic rst_n;

    wsd_in_if  in_ch ();
    wsd_out_if out_ch ();

    websocket_text_frame_deframer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // parser state as the block should hold it
    parse_phase_t phase;
    logic [63:0]  len_left;
    logic [2:0]   ext_due;
    logic [31:0]  key;
    logic [1:0]   key_idx;
    logic [1:0]   err_held;
    logic         masked;

    wsd_pkg::wsd_result_t expect_q[$];
    logic [7:0]           frame_bytes[$];

    int errors = 0;
    int n_bytes = 0;
    int n_buffers = 0;
    int n_results = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int hold_left = 0;
    int stuck = 0;
    bit calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_parser();
        phase    = HDR_FIRST;
        len_left = '0;
        ext_due  = '0;
        key      = '0;
        key_idx  = '0;
        err_held = wsd_pkg::ST_OK;
        masked   = 1'b0;
    endfunction

    function automatic void length_done();
        if (!masked)
        begin
            err_held = wsd_pkg::ST_UNMASKED;
            phase    = SKIP_TAIL;
        end
        else
        begin
            key_idx = '0;
            phase   = KEY_BYTES;
        end
    endfunction

    // append one byte to the buffer under construction
    function automatic void add_frame_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    // advance the parser by one byte and queue the beat it should produce, if any
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        wsd_pkg::wsd_result_t r;
        logic [1:0]           status;
        int                   sh;
        r      = '0;
        status = wsd_pkg::ST_OK;
        case (phase)
            HDR_FIRST:
            begin
                err_held = (b[3:0] != wsd_pkg::OPCODE_TEXT) ? wsd_pkg::ST_OPCODE
                                                             : wsd_pkg::ST_OK;
                phase    = (err_held != wsd_pkg::ST_OK) ? SKIP_TAIL : HDR_SECOND;
                status   = wsd_pkg::ST_TRUNC;
            end
            HDR_SECOND:
            begin
                masked   = b[7];
                len_left = '0;
                if (b[6:0] == wsd_pkg::LEN_CODE_16)
                begin
                    ext_due = wsd_pkg::EXT_LEFT_16;
                    phase   = EXT_LENGTH;
                    status  = wsd_pkg::ST_TRUNC;
                end
                else if (b[6:0] == wsd_pkg::LEN_CODE_64)
                begin
                    ext_due = wsd_pkg::EXT_LEFT_64;
                    phase   = EXT_LENGTH;
                    status  = wsd_pkg::ST_TRUNC;
                end
                else
                begin
                    len_left = 64'(b[6:0]);
                    length_done();
                    status = masked ? wsd_pkg::ST_TRUNC : wsd_pkg::ST_UNMASKED;
                end
            end
            EXT_LENGTH:
            begin
                len_left = {len_left[55:0], b};
                if (ext_due == 3'd0)
                begin
                    length_done();
                    status = masked ? wsd_pkg::ST_TRUNC : wsd_pkg::ST_UNMASKED;
                end
                else
                begin
                    ext_due = ext_due - 3'd1;
                    status  = wsd_pkg::ST_TRUNC;
                end
            end
            KEY_BYTES:
            begin
                key = {key[23:0], b};
                if (key_idx == 2'd3)
                begin
                    key_idx = '0;
                    phase   = (len_left == 64'd0) ? SKIP_TAIL : PAYLOAD_BYTES;
                    status  = (len_left == 64'd0) ? wsd_pkg::ST_OK : wsd_pkg::ST_TRUNC;
                end
                else
                begin
                    key_idx = key_idx + 2'd1;
                    status  = wsd_pkg::ST_TRUNC;
                end
            end
            PAYLOAD_BYTES:
            begin
                sh = 8 * (3 - int'(key_idx));
                r.payload_byte = b ^ key[sh +: 8];
                r.byte_valid   = 1'b1;
                key_idx  = key_idx + 2'd1;
                len_left = len_left - 64'd1;
                if (len_left == 64'd0)
                begin
                    phase  = SKIP_TAIL;
                    status = wsd_pkg::ST_OK;
                end
                else
                begin
                    status = wsd_pkg::ST_TRUNC;
                end
            end
            default:
                status = err_held;
        endcase
        if (r.byte_valid || last)
        begin
            r.has_result   = 1'b1;
            r.frame_done   = last;
            r.frame_status = last ? status : wsd_pkg::ST_OK;
            if (last)
                status_seen[status]++;
            expect_q.insert(expect_q.size(), r);
        end
        if (last)
            reset_parser();
    endfunction

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 28)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_buffer <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        deframe_byte(b, last);
        n_bytes++;
        @(negedge clk);
    endtask

    task automatic send_buffer();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        n_buffers++;
    endtask

    // drop valid and hold until every queued beat has come out
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] text_hdr();
        return {4'($urandom_range(15)), wsd_pkg::OPCODE_TEXT};
    endfunction

    function automatic void put_header(input logic [7:0] first, input logic mask_bit,
                                       input logic [63:0] len, input len_form_t form);
        add_frame_byte(first);
        case (form)
            LEN7:
                add_frame_byte({mask_bit, len[6:0]});
            LEN16:
            begin
                add_frame_byte({mask_bit, wsd_pkg::LEN_CODE_16});
                add_frame_byte(len[15:8]);
                add_frame_byte(len[7:0]);
            end
            default:
            begin
                add_frame_byte({mask_bit, wsd_pkg::LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    add_frame_byte(len[8*i +: 8]);
            end
        endcase
    endfunction

    function automatic void put_key_and_payload(input int n);
        for (int i = 0; i < 4 + n; i++)
            add_frame_byte(8'($urandom));
    endfunction

    function automatic void build_text_frame(input int plen);
        frame_bytes.delete();
        put_header(text_hdr(), 1'b1, 64'(plen), LEN7);
        put_key_and_payload(plen);
    endfunction

    task automatic send_random_buffer();
        int          pick;
        int          r;
        int          plen;
        int          cut;
        len_form_t   form;
        logic [7:0]  hdr;
        frame_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                form = LEN7;
                plen = $urandom_range(20);
            end
            else if (r < 70)
            begin
                form = LEN7;
                plen = $urandom_range(125, 100);
            end
            else if (r < 85)
            begin
                form = LEN16;
                plen = $urandom_range(40);
            end
            else if (r < 88)
            begin
                form = LEN16;
                plen = $urandom_range(300, 200);
            end
            else
            begin
                form = LEN64;
                plen = $urandom_range(30);
            end
            // well formed below 55, cut short from 55 to 71, MASK bit clear above
            put_header(text_hdr(), pick < 72, 64'(plen), form);
            if (pick < 72)
                put_key_and_payload(plen);
            else
                repeat ($urandom_range(4)) add_frame_byte(8'($urandom));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1)) add_frame_byte(8'($urandom));
            // cut some frames short anywhere
            if (pick >= 55 && pick < 72 && frame_bytes.size() > 1)
            begin
                cut = $urandom_range(frame_bytes.size() - 1, 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
        end
        else if (pick < 88)
        begin
            do
                hdr = 8'($urandom);
            while (hdr[3:0] == wsd_pkg::OPCODE_TEXT);
            add_frame_byte(hdr);
            repeat ($urandom_range(6)) add_frame_byte(8'($urandom));
        end
        else if (pick < 95)
        begin
            put_header(text_hdr(), 1'b1,
                       {8'($urandom_range(255, 1)), 24'($urandom), 32'($urandom)}, LEN64);
            put_key_and_payload($urandom_range(6));
        end
        else
        begin
            repeat ($urandom_range(8, 1)) add_frame_byte(8'($urandom));
        end
        send_buffer();
    endtask

    task automatic test_header_checks();
        frame_bytes = '{8'h81};
        send_buffer();
        frame_bytes = '{8'h8A, 8'h80};
        send_buffer();
        frame_bytes = '{8'h81, 8'h05};
        send_buffer();
        frame_bytes = '{8'h81, 8'h7E, 8'h00};
        send_buffer();
    endtask

    task automatic test_short_frames();
        frame_bytes = '{8'h81, 8'h80, 8'h11, 8'h22};
        send_buffer();
        // empty payload, FIN clear, ends on the last key byte
        frame_bytes = '{8'h01, 8'h80, 8'h5A, 8'hA5, 8'h3C, 8'hC3};
        send_buffer();
        // all-ones 64-bit length, buffer far too short
        frame_bytes = '{8'hF1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        send_buffer();
    endtask

    task automatic test_random_buffers(input int target);
        int start;
        start = n_bytes;
        while (n_bytes - start < target)
            send_random_buffer();
    endtask

    task automatic test_output_stall();
        hold_left = 400;
        repeat (6)
        begin
            build_text_frame(20 + $urandom_range(10));
            send_buffer();
        end
        pause_until_drained();
    endtask

    task automatic test_back_to_back(input int target);
        int start;
        start = n_bytes;
        calm  = 1'b1;
        while (n_bytes - start < target)
            send_random_buffer();
        calm = 1'b0;
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_beat
        wsd_pkg::wsd_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (expect_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: expected no beat, got byte %0h valid %0b done %0b status %0d",
                             $time, out_ch.payload_byte, out_ch.byte_valid,
                             out_ch.frame_done, out_ch.frame_status);
            end
            else
            begin
                want = expect_q.pop_front();
                compare_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                compare_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
                compare_field("frame_done", 8'(want.frame_done), 8'(out_ch.frame_done));
                compare_field("frame_status", 8'(want.frame_status), 8'(out_ch.frame_status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            stuck = 0;
        end
        else
        begin
            stuck++;
            if (stuck >= STALL_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles", $time, stuck);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(99) < 28)
            begin
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.end_of_buffer = 1'b0;
        rst_n = 1'b0;
        reset_parser();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_checks();
        test_short_frames();
        test_random_buffers(1100);
        test_output_stall();
        test_back_to_back(120);

        pause_until_drained();
        repeat (12) @(posedge clk);
        if (expect_q.size() != 0)
        begin
            errors += expect_q.size();
            $display("%0t ns: %0d beats expected but never seen, got none", $time,
                     expect_q.size());
        end
        $display("covered %0d buffers, %0d bytes, %0d output beats checked",
                 n_buffers, n_bytes, n_results);
        $display("closing status: ok %0d, truncated %0d, bad opcode %0d, unmasked %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
